>>> design/ddf_pkg.sv
// Package for the decimal digit display framer.
// Holds frame widths, driver register codes, the set-up frame table and the
// divide-by-ten constants. No dependencies.
package ddf_pkg;

  // Field widths of the channels.
  localparam int NUM_W  = 32;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 8;

  // Digit count limits and default.
  localparam int DEFAULT_NUM_DIGITS = 8;
  localparam int MAX_NUM_DIGITS     = 10;

  // Item kinds carried in the func field.
  localparam logic FUNC_INIT    = 1'b0;
  localparam logic FUNC_DISPLAY = 1'b1;

  // Set-up run: length and index width.
  localparam int INIT_FRAMES = 5;
  localparam int INIT_IDX_W  = $clog2(INIT_FRAMES);

  // Driver set-up register addresses.
  localparam logic [ADDR_W-1:0] ADDR_DECODE_MODE  = 4'h9;
  localparam logic [ADDR_W-1:0] ADDR_INTENSITY    = 4'hA;
  localparam logic [ADDR_W-1:0] ADDR_SCAN_LIMIT   = 4'hB;
  localparam logic [ADDR_W-1:0] ADDR_SHUTDOWN     = 4'hC;
  localparam logic [ADDR_W-1:0] ADDR_DISPLAY_TEST = 4'hF;

  // Driver set-up register values.
  localparam logic [DATA_W-1:0] DATA_DECODE_ALL   = 8'hFF;
  localparam logic [DATA_W-1:0] DATA_INTENSITY    = 8'h0F;
  localparam logic [DATA_W-1:0] DATA_SCAN_ALL     = 8'h07;
  localparam logic [DATA_W-1:0] DATA_NORMAL_OP    = 8'h01;
  localparam logic [DATA_W-1:0] DATA_TEST_OFF     = 8'h00;

  // Reciprocal of ten: floor(x / 10) == (x * RECIP10) >> RECIP_SHIFT for 32-bit x.
  localparam logic [NUM_W-1:0] RECIP10     = 32'hCCCC_CCCD;
  localparam int               RECIP_SHIFT = 35;

  // Queue between the front and the back.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  // One classified item as it waits in the queue.
  typedef struct packed {
    logic             disp;
    logic [NUM_W-1:0] number;
  } ddf_item_t;

  // One register frame.
  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } ddf_frame_t;

  // Set-up frame table, in send order.
  function automatic ddf_frame_t init_frame(input logic [INIT_IDX_W-1:0] idx);
    ddf_frame_t f;
    unique case (idx)
      3'd0:    f = '{addr: ADDR_DECODE_MODE,  data: DATA_DECODE_ALL};
      3'd1:    f = '{addr: ADDR_INTENSITY,    data: DATA_INTENSITY};
      3'd2:    f = '{addr: ADDR_SCAN_LIMIT,   data: DATA_SCAN_ALL};
      3'd3:    f = '{addr: ADDR_SHUTDOWN,     data: DATA_NORMAL_OP};
      default: f = '{addr: ADDR_DISPLAY_TEST, data: DATA_TEST_OFF};
    endcase
    return f;
  endfunction

endpackage

>>> design/ddf_in_if.sv
// Input channel of the display framer: command beats with func and number.
// Depends on ddf_pkg.
interface ddf_in_if import ddf_pkg::*; ();
  logic             valid;
  logic             ready;
  logic             func;
  logic [NUM_W-1:0] number;

  modport source (output valid, output func, output number, input ready);
  modport sink   (input valid, input func, input number, output ready);
endinterface

>>> design/ddf_out_if.sv
// Result channel of the display framer: one register frame per beat.
// Depends on ddf_pkg.
interface ddf_out_if import ddf_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [ADDR_W-1:0] reg_address;
  logic [DATA_W-1:0] reg_data;
  logic              last;

  modport source (output valid, output reg_address, output reg_data, output last,
                  input ready);
  modport sink   (input valid, input reg_address, input reg_data, input last,
                  output ready);
endinterface

>>> design/ddf_front.sv
// Front of the display framer: accepts command beats, classifies them and
// holds them in a two-entry queue for the back. Depends on ddf_pkg, ddf_in_if.
module ddf_front import ddf_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  ddf_in_if.sink    in_ch,
  output ddf_item_t q_item,
  output logic      q_valid,
  input  logic      q_ready
);

  ddf_item_t         mem_r [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QCNT_W-1:0] count_r, count_nxt;
  logic              push, pop;
  ddf_item_t         new_item;

  // Classify the incoming beat.
  always_comb begin
    new_item.disp   = (in_ch.func == FUNC_DISPLAY);
    new_item.number = in_ch.number;
  end

  // Queue handshakes.
  assign in_ch.ready = (count_r != QCNT_W'(QDEPTH));
  assign push        = in_ch.valid && in_ch.ready;
  assign q_valid     = (count_r != '0);
  assign pop         = q_valid && q_ready;
  assign q_item      = mem_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Queue storage; no reset needed on payload.
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= new_item;
    end
  end

  // The fill count never exceeds the queue depth.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= QCNT_W'(QDEPTH))
    else $error("queue fill count above depth");

  // The fill count tracks pushes and pops exactly.
  a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> count_r == $past(count_r) + QCNT_W'(1))
    else $error("queue fill count lost a push");

endmodule

>>> design/ddf_back.sv
// Back of the display framer: takes classified items from the queue and
// sends one register frame per cycle, while the receiver holds ready high,
// through a registered output stage. Depends on ddf_pkg, ddf_out_if.
module ddf_back import ddf_pkg::*; #(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
  input  logic      clk,
  input  logic      rst_n,
  input  ddf_item_t q_item,
  input  logic      q_valid,
  output logic      q_ready,
  ddf_out_if.source out_ch
);

  localparam int MAX_FRAMES = (NUM_DIGITS > INIT_FRAMES) ? NUM_DIGITS : INIT_FRAMES;
  localparam int CNT_W      = $clog2(MAX_FRAMES);

  // Sequencer state.
  logic              busy_r, busy_nxt;
  logic              disp_r, disp_nxt;
  logic [NUM_W-1:0]  num_r, num_nxt;
  logic [CNT_W-1:0]  idx_r, idx_nxt;

  // Output stage.
  logic              ovalid_r, ovalid_nxt;
  logic [ADDR_W-1:0] oaddr_r, oaddr_nxt;
  logic [DATA_W-1:0] odata_r, odata_nxt;
  logic              olast_r, olast_nxt;

  // Frame generation.
  ddf_frame_t        init_f;
  logic [2*NUM_W-1:0] prod;
  logic [NUM_W-1:0]  quot;
  logic [3:0]        quot_lo, ten_quot, digit;
  logic [ADDR_W-1:0] f_addr;
  logic [DATA_W-1:0] f_data;
  logic              f_last;
  logic              adv, emit, pop;

  // Divide by ten via the reciprocal; the digit needs only the low nibble.
  always_comb begin
    prod     = (2*NUM_W)'(num_r) * (2*NUM_W)'(RECIP10);
    quot     = NUM_W'(prod >> RECIP_SHIFT);
    quot_lo  = quot[3:0];
    ten_quot = 4'({quot_lo, 3'b000}) + 4'({quot_lo, 1'b0});
    digit    = num_r[3:0] - ten_quot;
  end

  // Current frame, either a digit position or a set-up entry.
  always_comb begin
    init_f = init_frame(idx_r[INIT_IDX_W-1:0]);
    if (disp_r) begin
      f_addr = ADDR_W'(idx_r) + ADDR_W'(1);
      f_data = DATA_W'(digit);
      f_last = (idx_r == CNT_W'(NUM_DIGITS - 1));
    end else begin
      f_addr = init_f.addr;
      f_data = init_f.data;
      f_last = (idx_r == CNT_W'(INIT_FRAMES - 1));
    end
  end

  // The output stage moves when empty or drained; the next item is taken
  // in the same cycle as the last frame of the current one.
  assign adv     = !ovalid_r || out_ch.ready;
  assign emit    = busy_r && adv;
  assign q_ready = !busy_r || (emit && f_last);
  assign pop     = q_valid && q_ready;

  // Sequencer and output stage next state.
  always_comb begin
    busy_nxt   = busy_r;
    disp_nxt   = disp_r;
    num_nxt    = num_r;
    idx_nxt    = idx_r;
    ovalid_nxt = ovalid_r;
    oaddr_nxt  = oaddr_r;
    odata_nxt  = odata_r;
    olast_nxt  = olast_r;
    if (adv) begin
      ovalid_nxt = emit;
    end
    if (emit) begin
      oaddr_nxt = f_addr;
      odata_nxt = f_data;
      olast_nxt = f_last;
      if (f_last) begin
        busy_nxt = 1'b0;
      end else begin
        idx_nxt = idx_r + CNT_W'(1);
        num_nxt = quot;
      end
    end
    if (pop) begin
      busy_nxt = 1'b1;
      disp_nxt = q_item.disp;
      num_nxt  = q_item.number;
      idx_nxt  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r   <= 1'b0;
      ovalid_r <= 1'b0;
      idx_r    <= '0;
    end else begin
      busy_r   <= busy_nxt;
      ovalid_r <= ovalid_nxt;
      idx_r    <= idx_nxt;
    end
  end

  // Payload registers need no reset.
  always_ff @(posedge clk) begin
    disp_r  <= disp_nxt;
    num_r   <= num_nxt;
    oaddr_r <= oaddr_nxt;
    odata_r <= odata_nxt;
    olast_r <= olast_nxt;
  end

  // Drive the result channel.
  assign out_ch.valid       = ovalid_r;
  assign out_ch.reg_address = oaddr_r;
  assign out_ch.reg_data    = odata_r;
  assign out_ch.last        = olast_r;

  // The frame index stays within the run of the item being sent.
  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> ((disp_r && idx_r <= CNT_W'(NUM_DIGITS - 1)) ||
                (!disp_r && idx_r <= CNT_W'(INIT_FRAMES - 1))))
    else $error("frame index beyond end of run");

  // A closing frame is the top digit position or the display test entry.
  a_last_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (ovalid_r && olast_r) |->
      (oaddr_r == ADDR_W'(NUM_DIGITS) || oaddr_r == ADDR_DISPLAY_TEST))
    else $error("closing frame at unexpected address");

  // Taking an item starts a fresh run at its first frame.
  a_pop_start: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> (busy_r && idx_r == '0))
    else $error("item taken without starting a run");

endmodule

>>> design/decimal_digit_display_framer_unit.sv
// Decimal digit display framer, top level.
// Ties the command front, the frame sequencer and the channel interfaces.
// Depends on ddf_pkg, ddf_in_if, ddf_out_if, ddf_front, ddf_back.
//
// Usage:
//   in_ch carries one command per beat: func 0 asks for the five set-up
//   frames, func 1 asks for number to be shown in decimal. out_ch carries one
//   register frame per beat (reg_address, reg_data) with last on the final
//   frame of each run. A display run holds NUM_DIGITS frames, units digit
//   first at address 1; digits above NUM_DIGITS are dropped and leading zeros
//   are sent as 0.
//   A command beat passes through the queue, the sequencer registers and
//   the registered output stage before its first frame appears on out_ch.
//   Throughput: one frame per cycle while the receiver holds ready high;
//   the frame sequencer splits off one decimal digit per frame with a
//   reciprocal multiply. A two-entry queue takes new commands while frames
//   are still going out.
//   Reset (rst_n low, synchronous) empties the queue and the output stage.
//   When the receiver holds ready low, the current frame stays on out_ch,
//   the sequencer waits, and in_ch keeps taking beats until the queue fills.
module decimal_digit_display_framer_unit import ddf_pkg::*; #(
  parameter int NUM_DIGITS = DEFAULT_NUM_DIGITS
) (
  input  logic       clk,
  input  logic       rst_n,
  ddf_in_if.sink     in_ch,
  ddf_out_if.source  out_ch
);

  ddf_item_t q_item;
  logic      q_valid;
  logic      q_ready;

  // Command intake and queue.
  ddf_front u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready)
  );

  // Frame sequencer and output stage.
  ddf_back #(
    .NUM_DIGITS (NUM_DIGITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_item  (q_item),
    .q_valid (q_valid),
    .q_ready (q_ready),
    .out_ch  (out_ch)
  );

endmodule
